// ----- rtl/wffa_pkg.sv -----
// shared constants and types for the worst-fit free list allocator
`default_nettype none

package wffa_pkg;

    // field widths
    localparam int OFF_W    = 32;
    localparam int SIZE_W   = 31;
    localparam int MARGIN_W = 8;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    // default table depth
    localparam int FREE_ENTRIES_DEF = 16;

    // split margin after reset
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd8;

    // register index, taken from the word address bit
    localparam logic REG_SPLIT_MARGIN = 1'b0;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_EXACT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SPLIT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPEND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    // one free block table entry
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } block_t;

    // running largest block of a scan
    typedef struct packed {
        logic   found;
        block_t blk;
    } best_t;

endpackage

`default_nettype wire

// ----- rtl/wffa_pick.sv -----
// running largest-block tracker fed by the table scan
`default_nettype none

module wffa_pick #(
    parameter int IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             cand_valid,
    input  wire logic [IDX_W-1:0] cand_idx,
    input  wire wffa_pkg::block_t cand,
    output wffa_pkg::best_t       best,
    output logic [IDX_W-1:0]      best_idx
);

    logic             found_reg;
    wffa_pkg::block_t blk_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             take;

    // table is stored oldest first, so ">=" lets the newest of equal sizes win
    assign take = cand_valid && (cand.size != '0)
                  && (!found_reg || (cand.size >= blk_reg.size));

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // winning entry payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_reg <= cand;
            idx_reg <= cand_idx;
        end
    end

    assign best.found = found_reg;
    assign best.blk   = blk_reg;
    assign best_idx   = idx_reg;

endmodule

`default_nettype wire

// ----- rtl/worst_fit_free_list_allocator.sv -----
// worst-fit free list allocator top level
//
// A request beat is taken when start is high and busy is low: func selects
// allocate or free, req_size is the block size, free_offset the freed block.
// Each request gives exactly one result beat: done is high for one cycle with
// place_offset and status; the receiver cannot stall it.
// The free block table sits in one synchronous RAM, oldest entry at the
// lowest address. A free writes the next slot and answers in the next cycle
// (or reports the table full). An allocate scans the table one entry per
// cycle through the RAM read port, picks the largest block (newest on a tie),
// then splits, reuses or appends at the end of the store.
// When an exact match lies below the newest entry, the newer entries are
// moved down one slot over it, one at a time through the single RAM port.
// busy stays high until the result beat; the next request may start in the
// cycle of done.
// split_margin is written through the APB port at address 0; the user must
// write it only while idle, as the block does not enforce it.
// Reset empties the table, clears the store end and sets the margin to 8.
`default_nettype none

module worst_fit_free_list_allocator #(
    parameter int FREE_ENTRIES = wffa_pkg::FREE_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [wffa_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [wffa_pkg::OFF_W-1:0]    free_offset,
    // result channel
    output logic                               done,
    output logic [wffa_pkg::OFF_W-1:0]         place_offset,
    output logic [wffa_pkg::STATUS_W-1:0]      status,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wffa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [wffa_pkg::DATA_W-1:0]   pwdata,
    output logic [wffa_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(FREE_ENTRIES);
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_ENTRIES);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_SHIFT  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [wffa_pkg::OFF_W-1:0]      end_reg, end_next;
    logic [wffa_pkg::MARGIN_W-1:0]   margin_reg;
    logic [CNT_W-1:0]                rd_idx_reg, rd_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic [wffa_pkg::SIZE_W-1:0]     req_reg, req_next;
    logic                            done_reg, done_next;
    logic [wffa_pkg::OFF_W-1:0]      place_reg, place_next;
    logic [wffa_pkg::STATUS_W-1:0]   status_reg, status_next;

    // table RAM and its ports
    wffa_pkg::block_t                mem [FREE_ENTRIES];
    wffa_pkg::block_t                rd_data_reg;
    logic                            mem_re;
    logic [IDX_W-1:0]                mem_ra;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_wa;
    wffa_pkg::block_t                mem_wd;

    // scan and decision signals
    logic                            pick_clear;
    logic                            pick_valid;
    wffa_pkg::best_t                 best;
    logic [IDX_W-1:0]                best_idx;
    logic [CNT_W-1:0]                cnt_last;
    logic                            issue;
    logic                            last_cmp;
    logic                            is_exact;
    logic                            is_split;
    logic                            cfg_write;

    // table RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // largest block tracker
    assign pick_valid = cmp_valid_reg && (state_reg == S_SCAN);

    wffa_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (pick_clear),
        .cand_valid (pick_valid),
        .cand_idx   (cmp_idx_reg),
        .cand       (rd_data_reg),
        .best       (best),
        .best_idx   (best_idx)
    );

    // helpers for the sequencer
    assign cnt_last = count_reg - CNT_W'(1);
    assign issue    = rd_idx_reg < count_reg;
    assign last_cmp = cmp_valid_reg && (CNT_W'(cmp_idx_reg) == cnt_last);
    assign is_exact = best.found && (req_reg == best.blk.size);
    // req < size - margin as signed, rewritten as req + margin < size
    assign is_split = best.found
                      && (({1'b0, req_reg} + wffa_pkg::OFF_W'(margin_reg))
                          < {1'b0, best.blk.size});

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        end_next       = end_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        req_next       = req_reg;
        done_next      = 1'b0;
        place_next     = place_reg;
        status_next    = status_reg;
        mem_re         = 1'b0;
        mem_ra         = rd_idx_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        pick_clear     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_size;
                    if (func == wffa_pkg::FUNC_FREE)
                    begin
                        place_next = free_offset;
                        done_next  = 1'b1;
                        if (count_reg == CNT_FULL)
                        begin
                            status_next = wffa_pkg::ST_FULL;
                        end
                        else
                        begin
                            // newest entry goes to the next free slot
                            mem_we      = 1'b1;
                            mem_wa      = count_reg[IDX_W-1:0];
                            mem_wd      = '{offset: free_offset, size: req_size};
                            count_next  = count_reg + CNT_W'(1);
                            status_next = wffa_pkg::ST_FREED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: place at the store end
                        place_next  = end_reg;
                        end_next    = end_reg + {1'b0, req_size};
                        status_next = wffa_pkg::ST_APPEND;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        pick_clear  = 1'b1;
                        rd_idx_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // one read per cycle, compared in the next cycle
                mem_re         = issue;
                cmp_valid_next = issue;
                cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (last_cmp)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (is_exact)
                begin
                    place_next  = best.blk.offset;
                    status_next = wffa_pkg::ST_EXACT;
                    if (CNT_W'(best_idx) == cnt_last)
                    begin
                        // newest entry removed, nothing to move
                        count_next = cnt_last;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = CNT_W'(best_idx) + CNT_W'(1);
                        state_next  = S_SHIFT;
                    end
                end
                else if (is_split)
                begin
                    // front of the block is handed out, entry keeps the rest
                    mem_we      = 1'b1;
                    mem_wa      = best_idx;
                    mem_wd      = '{offset: best.blk.offset + {1'b0, req_reg},
                                    size:   best.blk.size - req_reg};
                    place_next  = best.blk.offset;
                    status_next = wffa_pkg::ST_SPLIT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    place_next  = end_reg;
                    end_next    = end_reg + {1'b0, req_reg};
                    status_next = wffa_pkg::ST_APPEND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_SHIFT:
            begin
                // move newer entries down one slot over the removed one
                mem_re         = issue;
                cmp_valid_next = issue;
                cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = cmp_idx_reg - IDX_W'(1);
                    mem_wd = rd_data_reg;
                end
                if (last_cmp)
                begin
                    count_next = cnt_last;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            end_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            end_reg       <= end_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        place_reg   <= place_next;
        status_reg  <= status_next;
    end

    // configuration register
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= wffa_pkg::MARGIN_RESET;
        end
        else if (cfg_write && (paddr[wffa_pkg::PADDR_W-1] == wffa_pkg::REG_SPLIT_MARGIN))
        begin
            margin_reg <= pwdata[wffa_pkg::MARGIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[wffa_pkg::PADDR_W-1] == wffa_pkg::REG_SPLIT_MARGIN)
                    ? wffa_pkg::DATA_W'(margin_reg) : '0;

    // outputs
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign place_offset = place_reg;
    assign status       = status_reg;

    // the result beat always lands with the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    // entry count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count beyond table depth");

    // a free into a full table is answered at once as dropped
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == wffa_pkg::FUNC_FREE) && (count_reg == CNT_FULL))
        |=> (done && (status == wffa_pkg::ST_FULL) && (count_reg == CNT_FULL)))
        else $error("free into full table not dropped");

    // gap closing only runs with an entry above the removed one
    a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (count_reg >= CNT_W'(2)))
        else $error("entry move with too few entries");

endmodule

`default_nettype wire

// ----- tb/tb_worst_fit_free_list_allocator.sv -----
// testbench for the worst-fit free list allocator: directed and random requests
`timescale 1ns / 100ps

module tb_worst_fit_free_list_allocator;
    import wffa_pkg::*;

    localparam logic [PADDR_W-1:0] MARGIN_ADDR = {REG_SPLIT_MARGIN, 2'b00};
    localparam int PHASE_ITEMS = 390;
    localparam int MAX_GAP = 20;
    localparam int DRAIN_CYCLES = 2 * FREE_ENTRIES_DEF + 8;

    // free block table model and queue of expected result beats
    class alloc_scoreboard;
        logic [OFF_W-1:0]    blk_off[$];
        logic [SIZE_W-1:0]   blk_size[$];
        logic [OFF_W-1:0]    store_end;
        logic [MARGIN_W-1:0] margin;
        logic [OFF_W-1:0]    exp_off[$];
        logic [STATUS_W-1:0] exp_status[$];
        int                  depth;
        int                  fail_count;

        function new(int table_depth);
            depth = table_depth;
            store_end = '0;
            margin = MARGIN_RESET;
            fail_count = 0;
        endfunction

        // index of the largest nonzero block, newest first on a tie; -1 if none
        function int largest_index();
            int best;
            logic [SIZE_W-1:0] top;
            best = -1;
            top = '0;
            for (int i = 0; i < blk_size.size(); i++)
            begin
                if (blk_size[i] > top)
                begin
                    top = blk_size[i];
                    best = i;
                end
            end
            return best;
        endfunction

        function logic [SIZE_W-1:0] largest_size();
            int b;
            b = largest_index();
            return (b < 0) ? '0 : blk_size[b];
        endfunction

        function int entries();
            return blk_size.size();
        endfunction

        function int pending();
            return exp_off.size();
        endfunction

        // apply one accepted request and queue its result
        function void note_request(logic f, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off);
            int b;
            logic [SIZE_W-1:0] top;
            logic [OFF_W-1:0] place;
            logic [STATUS_W-1:0] st;
            if (f == FUNC_FREE)
            begin
                place = off;
                if (blk_off.size() >= depth)
                    st = ST_FULL;
                else
                begin
                    blk_off.insert(0, off);
                    blk_size.insert(0, sz);
                    st = ST_FREED;
                end
            end
            else
            begin
                b = largest_index();
                top = (b < 0) ? '0 : blk_size[b];
                if (b >= 0 && sz == top)
                begin
                    place = blk_off[b];
                    blk_off.delete(b);
                    blk_size.delete(b);
                    st = ST_EXACT;
                end
                else if (b >= 0 && longint'(sz) < longint'(top) - longint'(margin))
                begin
                    place = blk_off[b];
                    blk_off[b] = blk_off[b] + sz;
                    blk_size[b] = top - sz;
                    st = ST_SPLIT;
                end
                else
                begin
                    place = store_end;
                    store_end = store_end + sz;
                    st = ST_APPEND;
                end
            end
            exp_off.insert(exp_off.size(), place);
            exp_status.insert(exp_status.size(), st);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [OFF_W-1:0] off, logic [STATUS_W-1:0] st);
            logic [OFF_W-1:0] e_off;
            logic [STATUS_W-1:0] e_st;
            if (exp_off.size() == 0)
            begin
                $error("result beat with no request pending: place_offset %h status %0d",
                       off, st);
                fail_count++;
                return;
            end
            e_off = exp_off.pop_front();
            e_st = exp_status.pop_front();
            if (off !== e_off)
            begin
                $error("place_offset mismatch: expected %h, actual %h", e_off, off);
                fail_count++;
            end
            if (st !== e_st)
            begin
                $error("status mismatch: expected %0d, actual %0d", e_st, st);
                fail_count++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                func = FUNC_ALLOC;
    logic [SIZE_W-1:0]   req_size = '0;
    logic [OFF_W-1:0]    free_offset = '0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    wire                 busy;
    wire                 done;
    wire [OFF_W-1:0]     place_offset;
    wire [STATUS_W-1:0]  status;
    wire [DATA_W-1:0]    prdata;
    wire                 pready;

    alloc_scoreboard sb;
    int sender_idle_pct = 0;

    worst_fit_free_list_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .req_size     (req_size),
        .free_offset  (free_offset),
        .done         (done),
        .place_offset (place_offset),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result beats are checked as they appear
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(place_offset, status);
    end

    // run limit
    initial
    begin
        #2000000;
        $display("** worst_fit_free_list_allocator: FAILED **");
        $finish;
    end

    // one request beat, then a random sender gap
    task automatic send_request(input logic f, input logic [SIZE_W-1:0] sz,
                                input logic [OFF_W-1:0] off);
        int gap;
        start <= 1'b1;
        func <= f;
        req_size <= sz;
        free_offset <= off;
        do @(posedge clk); while (busy);
        sb.note_request(f, sz, off);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one bus transfer; psel is left high for a following transfer
    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MARGIN_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    // stop requests, drain, then write and read back the margin
    task automatic set_margin(input logic [MARGIN_W-1:0] value);
        logic [DATA_W-1:0] rd;
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        apb_access(1'b1, DATA_W'(value), rd);
        sb.margin = value;
        apb_access(1'b0, '0, rd);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(value))
        begin
            $error("split_margin mismatch: expected %h, actual %h", DATA_W'(value), rd);
            sb.fail_count++;
        end
    endtask

    // mostly small sizes, with zero and the far top of the range
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return SIZE_W'($urandom_range(1, 4096));
        else if (r < 80)
            return '0;
        else if (r < 90)
            return SIZE_W'($urandom());
        else
            return {SIZE_W{1'b1}} - SIZE_W'($urandom_range(0, 64));
    endfunction

    // random request aimed at exact, split, boundary and append cases
    task automatic random_item(input int free_pct);
        int mode;
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] sz;
        top = sb.largest_size();
        if ($urandom_range(99) < free_pct)
            send_request(FUNC_FREE, pick_size(), $urandom());
        else
        begin
            mode = $urandom_range(9);
            if (top == 0 || mode >= 7)
                sz = pick_size();
            else if (mode < 3)
                sz = top;
            else if (top <= sb.margin)
                sz = SIZE_W'($urandom_range(0, top));
            else if (mode < 6)
                sz = SIZE_W'($urandom_range(0, top - sb.margin - 1));
            else
                sz = top - sb.margin - SIZE_W'($urandom_range(0, 1));
            send_request(FUNC_ALLOC, sz, $urandom());
        end
    endtask

    initial
    begin
        int free_pct;
        logic [MARGIN_W-1:0] margins[5];
        int idles[5];
        sb = new(FREE_ENTRIES_DEF);
        margins = '{8'd0, 8'd255, 8'($urandom()), 8'd1, 8'($urandom())};
        idles = '{0, 78, 20, 78, 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table and zero-size blocks append
        send_request(FUNC_ALLOC, '0, 32'h1234_5678);
        send_request(FUNC_ALLOC, {SIZE_W{1'b1}}, '0);
        send_request(FUNC_FREE, '0, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 31'd16, '0);
        // tie goes to the newest block, then split at the margin edge
        send_request(FUNC_FREE, 31'd50, 32'h0000_1000);
        send_request(FUNC_FREE, 31'd50, 32'h0000_2000);
        send_request(FUNC_ALLOC, 31'd50, '0);
        send_request(FUNC_ALLOC, 31'd41, '0);
        send_request(FUNC_ALLOC, 31'd1, '0);
        // margin above the largest block: no split
        send_request(FUNC_FREE, 31'd3, 32'h0000_3000);
        send_request(FUNC_ALLOC, 31'd9, '0);
        send_request(FUNC_ALLOC, '0, '0);
        // split wraps the entry offset, append wraps the store end
        send_request(FUNC_FREE, {SIZE_W{1'b1}}, 32'hFFFF_FFF0);
        send_request(FUNC_ALLOC, 31'h10, '0);
        send_request(FUNC_ALLOC, {SIZE_W{1'b1}}, '0);
        send_request(FUNC_FREE, {SIZE_W{1'b1}}, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, {SIZE_W{1'b1}}, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, '0, '0);
        // fill the table, then one free too many
        while (sb.entries() < FREE_ENTRIES_DEF)
            send_request(FUNC_FREE, SIZE_W'($urandom_range(1, 255)), $urandom());
        send_request(FUNC_FREE, 31'd77, 32'hA5A5_5A5A);

        // random phases over margin settings and sender idling
        for (int p = 0; p < 5; p++)
        begin
            set_margin(margins[p]);
            sender_idle_pct = idles[p];
            free_pct = 40;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    free_pct = $urandom_range(20, 60);
                random_item(free_pct);
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("** worst_fit_free_list_allocator: PASSED **");
        else
            $display("** worst_fit_free_list_allocator: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wffa_pkg.sv
rtl/wffa_pick.sv
rtl/worst_fit_free_list_allocator.sv
tb/tb_worst_fit_free_list_allocator.sv
